// File: hdl/pcet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcet_pkg
// Types and constants shared by the piecewise clock epoch table.
// ----------------------------------------------------------------------------
package pcet_pkg;

    localparam int NODE_COUNT         = 16;
    localparam int EPOCHS_PER_NODE    = 16;
    localparam int SKEW_FRACTION_BITS = 24;

    localparam int NODE_W  = 4;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int ADDR_W  = NODE_W + SLOT_W;

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_APPEND = 3'd0;
    localparam cmd_t CMD_INSERT = 3'd1;
    localparam cmd_t CMD_L2G    = 3'd2;
    localparam cmd_t CMD_G2L    = 3'd3;
    localparam cmd_t CMD_MAX    = 3'd4;
    localparam cmd_t CMD_PRUNE  = 3'd5;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_MALFORMED = 3'd1;
    localparam status_t ST_NOT_CONTIG = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_NO_EPOCHS = 3'd4;
    localparam status_t ST_ZERO_SKEW = 3'd5;

    typedef struct packed {
        logic [63:0] gs;
        logic [63:0] ge;
        logic [63:0] ls;
        logic [63:0] le;
        logic [31:0] rate;
    } epoch_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_LAST_RD,
        S_LAST_WAIT,
        S_LAST_CHK,
        S_SCAN_RD,
        S_SCAN_WAIT,
        S_SCAN_CHK,
        S_CUT_WR,
        S_PUSH,
        S_BS_RD,
        S_BS_WAIT,
        S_BS_CHK,
        S_CONV_SETUP,
        S_MUL,
        S_DIV,
        S_ADD,
        S_PRUNE_NEXT,
        S_DONE
    } state_t;

    function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage : pcet_pkg
`default_nettype wire

// File: hdl/piecewise_clock_epoch_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_clock_epoch_table_top
// Per-node clock epoch lists with append, insert, max, conversion and prune.
// ----------------------------------------------------------------------------
// One request at a time. Max reads the last epoch of the list, as does append
// to a non-empty list; insert scans the list one epoch at a time; a conversion
// runs a binary search of up to 5 probes plus a read of the chosen epoch, then
// shift registers shared by a shift-add multiply for global to local and a
// shift-subtract divide for local to global (one quotient bit per cycle). Prune
// runs the search for each of the 16 nodes whose list is not empty. The result
// waits in an output register; the next request is taken no earlier than the
// cycle in which that result is delivered.
module piecewise_clock_epoch_table_top (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  [2:0]           command,
    input  wire  [3:0]           node,
    input  wire  signed [63:0]   global_start,
    input  wire  signed [63:0]   global_end,
    input  wire  signed [63:0]   local_start,
    input  wire  signed [63:0]   local_end,
    input  wire  [31:0]          rate_ratio,
    input  wire  signed [63:0]   query_time,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [2:0]           status,
    output logic signed [63:0]   converted_time,
    output logic signed [63:0]   second_time,
    output logic [3:0]           epoch_slot
);
    import pcet_pkg::*;

    epoch_t mem [NODE_COUNT*EPOCHS_PER_NODE];
    epoch_t rd_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_wa, mem_ra;
    epoch_t               mem_wd;

    logic [COUNT_W-1:0] cnt_reg [NODE_COUNT];
    logic [SLOT_W-1:0]  head_reg [NODE_COUNT];

    state_t state_reg, state_next;

    cmd_t        cmd_reg;
    logic [3:0]  node_reg;
    epoch_t      in_reg;
    logic [63:0] q_reg;

    logic signed [5:0] lo_reg, lo_next, hi_reg, hi_next, fl_reg, fl_next;
    logic [COUNT_W-1:0] mid_reg, mid_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;

    logic [127:0] acc_reg, acc_next;
    logic [63:0]  mag_reg, mag_next;
    logic [31:0]  k_reg, k_next;
    logic [64:0]  rem_reg, rem_next;
    logic [6:0]   it_reg, it_next;
    logic         neg_reg, neg_next;
    logic [63:0]  base_reg, base_next;

    logic [2:0]  st_reg, st_next;
    logic [63:0] t1_reg, t1_next, t2_reg, t2_next;
    logic [3:0]  slot_reg, slot_next;
    logic        ov_reg;

    logic [COUNT_W-1:0] cnt_cur;
    logic [SLOT_W-1:0]  head_cur;
    logic               g2l;
    logic [63:0]        s_v, t_v, ref_v;
    logic               cnt_we, head_we;
    logic [COUNT_W-1:0] cnt_wd;
    logic [SLOT_W-1:0]  head_wd;
    logic [127:0]       sh;
    logic [64:0]        trial;
    logic [64:0]        ub_sum;

    assign cnt_cur  = cnt_reg[node_reg];
    assign head_cur = head_reg[node_reg];
    assign g2l      = (cmd_reg == CMD_G2L) || (cmd_reg == CMD_PRUNE);
    assign s_v      = g2l ? rd_reg.gs : rd_reg.ls;
    assign t_v      = g2l ? rd_reg.ge : rd_reg.le;
    assign ref_v    = s_v;

    assign in_ready       = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign converted_time = t1_reg;
    assign second_time    = t2_reg;
    assign epoch_slot     = slot_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cnt_we)
            begin
                cnt_reg[node_reg] <= cnt_wd;
            end
            if (head_we)
            begin
                head_reg[node_reg] <= head_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= command;
            node_reg <= (command == CMD_PRUNE) ? 4'd0 : node;
            in_reg   <= '{gs: global_start, ge: global_end, ls: local_start,
                          le: local_end, rate: rate_ratio};
            q_reg    <= query_time;
        end
        else if (state_reg == S_PRUNE_NEXT)
        begin
            node_reg <= node_reg + 4'd1;
        end
        lo_reg <= lo_next; hi_reg <= hi_next; fl_reg <= fl_next;
        mid_reg <= mid_next; idx_reg <= idx_next;
        acc_reg <= acc_next; mag_reg <= mag_next; k_reg <= k_next;
        rem_reg <= rem_next; it_reg <= it_next; neg_reg <= neg_next;
        base_reg <= base_next;
        st_reg <= st_next; t1_reg <= t1_next; t2_reg <= t2_next;
        slot_reg <= slot_next;
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next = lo_reg; hi_next = hi_reg; fl_next = fl_reg;
        mid_next = mid_reg; idx_next = idx_reg;
        acc_next = acc_reg; mag_next = mag_reg; k_next = k_reg;
        rem_next = rem_reg; it_next = it_reg; neg_next = neg_reg;
        base_next = base_reg;
        st_next = st_reg; t1_next = t1_reg; t2_next = t2_reg;
        slot_next = slot_reg;
        mem_we = 1'b0; mem_re = 1'b0; mem_wa = '0; mem_wd = in_reg; mem_ra = '0;
        cnt_we = 1'b0; cnt_wd = cnt_cur; head_we = 1'b0; head_wd = head_cur;
        sh = '0; trial = '0; ub_sum = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                st_next = ST_OK; t1_next = '0; t2_next = '0; slot_next = '0;
                idx_next = '0;
                case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (!slt(in_reg.gs, in_reg.ge) || !slt(in_reg.ls, in_reg.le))
                        begin
                            st_next = ST_MALFORMED; state_next = S_DONE;
                        end
                        else if (in_reg.rate == '0)
                        begin
                            st_next = ST_ZERO_SKEW; state_next = S_DONE;
                        end
                        else if (cnt_cur != '0)
                        begin
                            state_next = S_LAST_RD;
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (in_reg.rate == '0)
                        begin
                            st_next = ST_ZERO_SKEW; state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    CMD_L2G, CMD_G2L:
                    begin
                        if (cnt_cur == '0)
                        begin
                            st_next = ST_NO_EPOCHS; t1_next = q_reg;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            lo_next = '0; fl_next = -6'sd1;
                            hi_next = $signed({1'b0, cnt_cur}) - 6'sd1;
                            state_next = S_BS_RD;
                        end
                    end
                    CMD_MAX:
                    begin
                        if (cnt_cur == '0)
                        begin
                            st_next = ST_NO_EPOCHS; state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_LAST_RD;
                        end
                    end
                    CMD_PRUNE:
                    begin
                        if (cnt_cur != '0)
                        begin
                            lo_next = '0; fl_next = -6'sd1;
                            hi_next = $signed({1'b0, cnt_cur}) - 6'sd1;
                            state_next = S_BS_RD;
                        end
                        else
                        begin
                            state_next = S_PRUNE_NEXT;
                        end
                    end
                    default:
                    begin
                        st_next = ST_MALFORMED; state_next = S_DONE;
                    end
                endcase
            end
            S_LAST_RD:
            begin
                mem_re = 1'b1;
                mem_ra = {node_reg, head_cur + cnt_cur[SLOT_W-1:0] - 4'd1};
                state_next = S_LAST_WAIT;
            end
            S_LAST_WAIT:
            begin
                state_next = S_LAST_CHK;
            end
            S_LAST_CHK:
            begin
                if (cmd_reg == CMD_MAX)
                begin
                    t1_next = rd_reg.le; t2_next = rd_reg.ge;
                    slot_next = cnt_cur[SLOT_W-1:0] - 4'd1;
                    state_next = S_DONE;
                end
                else if (rd_reg.ge != in_reg.gs || rd_reg.le != in_reg.ls)
                begin
                    st_next = ST_NOT_CONTIG; state_next = S_DONE;
                end
                else if (cnt_cur >= COUNT_W'(EPOCHS_PER_NODE))
                begin
                    st_next = ST_FULL; state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg >= cnt_cur)
                begin
                    if (cnt_cur >= COUNT_W'(EPOCHS_PER_NODE))
                    begin
                        st_next = ST_FULL; state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_ra = {node_reg, head_cur + idx_reg[SLOT_W-1:0]};
                    state_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (!slt(in_reg.gs, rd_reg.gs) && !slt(rd_reg.ge, in_reg.gs))
                begin
                    state_next = S_CUT_WR;
                end
                else
                begin
                    idx_next = idx_reg + 5'd1;
                    state_next = S_SCAN_RD;
                end
            end
            S_CUT_WR:
            begin
                cnt_we = 1'b1;
                if (rd_reg.gs == in_reg.gs)
                begin
                    cnt_wd = idx_reg;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wa = {node_reg, head_cur + idx_reg[SLOT_W-1:0]};
                    mem_wd = rd_reg;
                    mem_wd.ge = in_reg.gs;
                    mem_wd.le = in_reg.ls;
                    cnt_wd = idx_reg + 5'd1;
                end
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                mem_we = 1'b1;
                mem_wa = {node_reg, head_cur + cnt_cur[SLOT_W-1:0]};
                mem_wd = in_reg;
                cnt_we = 1'b1;
                cnt_wd = cnt_cur + 5'd1;
                slot_next = cnt_cur[SLOT_W-1:0];
                state_next = S_DONE;
            end
            S_BS_RD:
            begin
                if (lo_reg > hi_reg)
                begin
                    mid_next = (fl_reg < 0) ? '0 : fl_reg[COUNT_W-1:0];
                    mem_re = 1'b1;
                    mem_ra = {node_reg, head_cur +
                              ((fl_reg < 0) ? 4'd0 : fl_reg[SLOT_W-1:0])};
                    state_next = (cmd_reg == CMD_PRUNE) ? S_PRUNE_NEXT : S_CONV_SETUP;
                    if (cmd_reg != CMD_PRUNE)
                    begin
                        state_next = S_BS_WAIT;
                        it_next = 7'd1;
                    end
                end
                else
                begin
                    mid_next = COUNT_W'((lo_reg + hi_reg) >>> 1);
                    mem_re = 1'b1;
                    mem_ra = {node_reg, head_cur + mid_next[SLOT_W-1:0]};
                    it_next = 7'd0;
                    state_next = S_BS_WAIT;
                end
            end
            S_BS_WAIT:
            begin
                state_next = (it_reg == 7'd1) ? S_CONV_SETUP : S_BS_CHK;
            end
            S_BS_CHK:
            begin
                if (!slt(q_reg, s_v) && slt(q_reg, t_v))
                begin
                    fl_next = $signed({1'b0, mid_reg});
                    lo_next = 6'sd1; hi_next = 6'sd0;
                end
                else if (slt(q_reg, s_v))
                begin
                    if (mid_reg == '0)
                    begin
                        lo_next = 6'sd1; hi_next = 6'sd0;
                    end
                    else
                    begin
                        hi_next = $signed({1'b0, mid_reg}) - 6'sd1;
                    end
                end
                else
                begin
                    fl_next = $signed({1'b0, mid_reg});
                    lo_next = $signed({1'b0, mid_reg}) + 6'sd1;
                end
                state_next = S_BS_RD;
            end
            S_CONV_SETUP:
            begin
                slot_next = mid_reg[SLOT_W-1:0];
                neg_next  = slt(q_reg, ref_v);
                mag_next  = slt(q_reg, ref_v) ? ref_v - q_reg : q_reg - ref_v;
                base_next = g2l ? rd_reg.ls : rd_reg.gs;
                k_next    = rd_reg.rate;
                acc_next  = '0;
                rem_next  = '0;
                it_next   = '0;
                if (g2l)
                begin
                    state_next = S_MUL;
                end
                else if (rd_reg.rate == '0)
                begin
                    acc_next = '1; state_next = S_ADD;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_MUL:
            begin
                if (k_reg[it_reg[4:0]])
                begin
                    acc_next = acc_reg + ({64'b0, mag_reg} << it_reg[4:0]);
                end
                it_next = it_reg + 7'd1;
                if (it_reg == 7'd31)
                begin
                    state_next = S_ADD;
                end
            end
            S_DIV:
            begin
                sh = {40'b0, mag_reg, 24'b0};
                trial = {rem_reg[63:0], sh[7'd87 - it_reg]};
                if (trial >= {33'b0, k_reg})
                begin
                    rem_next = trial - {33'b0, k_reg};
                    acc_next = {acc_reg[126:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    acc_next = {acc_reg[126:0], 1'b0};
                end
                it_next = it_reg + 7'd1;
                if (it_reg == 7'd87)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (g2l)
                begin
                    sh = acc_reg >> SKEW_FRACTION_BITS;
                end
                else
                begin
                    sh = acc_reg;
                end
                if (!neg_reg)
                begin
                    ub_sum = {1'b0, base_reg ^ 64'h8000_0000_0000_0000} + {1'b0, sh[63:0]};
                    if (sh[127:64] != '0 || ub_sum[64])
                    begin
                        t1_next = 64'h7fff_ffff_ffff_ffff;
                    end
                    else
                    begin
                        t1_next = ub_sum[63:0] ^ 64'h8000_0000_0000_0000;
                    end
                end
                else
                begin
                    ub_sum = {1'b0, base_reg ^ 64'h8000_0000_0000_0000} - {1'b0, sh[63:0]};
                    if (sh[127:64] != '0 || ub_sum[64])
                    begin
                        t1_next = 64'h8000_0000_0000_0000;
                    end
                    else
                    begin
                        t1_next = ub_sum[63:0] ^ 64'h8000_0000_0000_0000;
                    end
                end
                state_next = S_DONE;
            end
            S_PRUNE_NEXT:
            begin
                if (cnt_cur != '0)
                begin
                    head_we = 1'b1;
                    head_wd = head_cur + mid_reg[SLOT_W-1:0];
                    cnt_we  = 1'b1;
                    cnt_wd  = cnt_cur - mid_reg;
                end
                if (node_reg == 4'(NODE_COUNT - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next = '0;
                    state_next = S_DECODE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_one_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |=> (cnt_reg[$past(node_reg)] ==
                                    $past(cnt_reg[node_reg]) + 5'd1))
        else $error("push did not bump count");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |->
            (cnt_reg[node_reg] <= COUNT_W'(EPOCHS_PER_NODE + 1)))
        else $error("node count overflow");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result not presented");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready while busy");
endmodule : piecewise_clock_epoch_table_top
`default_nettype wire
